>>> design/dpt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpt_pkg
// Shared constants and types of the demand paging translator.
// ----------------------------------------------------------------------------
package dpt_pkg;

   localparam int PAGE_BITS     = 12;
   localparam int PAGE_NUM_BITS = 10;
   localparam int NUM_FRAMES    = 8;
   localparam int FRAME_BITS    = $clog2(NUM_FRAMES);
   localparam int PAGE_COUNT    = 1 << PAGE_NUM_BITS;
   localparam int ADDR_W        = 22;
   localparam int PHYS_W        = 15;
   localparam int LIMIT_W       = 4;
   localparam int LFSR_W        = 16;

   localparam logic [LFSR_W-1:0]  LFSR_SEED   = 16'hACE1;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 4'd8;

   // One write into the slot table.
   typedef struct packed {
      logic                     en;
      logic [FRAME_BITS-1:0]    index;
      logic [PAGE_NUM_BITS-1:0] page;
   } slot_wr_type;

   // Outcome of the associative search.
   typedef struct packed {
      logic                  hit;
      logic [FRAME_BITS-1:0] frame;
   } slot_hit_type;

endpackage
`default_nettype wire

>>> design/dpt_slots.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpt_slots
// Fully associative slot table: slot i owns physical frame i.
// ----------------------------------------------------------------------------
module dpt_slots
   import dpt_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [PAGE_NUM_BITS-1:0] lookup_page,
   output      slot_hit_type             lookup,
   input  wire slot_wr_type              wr,
   input  wire logic [FRAME_BITS-1:0]    victim_index,
   output      logic [PAGE_NUM_BITS-1:0] victim_page
);

   logic [NUM_FRAMES-1:0]    valid_ff;
   logic [PAGE_NUM_BITS-1:0] page_ff [NUM_FRAMES];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.index] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         page_ff[wr.index] <= wr.page;
      end
   end

   // Resident pages are unique, so the lowest matching slot is the only one.
   always_comb begin
      lookup.hit   = 1'b0;
      lookup.frame = '0;
      for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
         if (valid_ff[i] && (page_ff[i] == lookup_page)) begin
            lookup.hit   = 1'b1;
            lookup.frame = FRAME_BITS'(i);
         end
      end
   end

   assign victim_page = page_ff[victim_index];

endmodule
`default_nettype wire

>>> design/dpt_swap_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpt_swap_mem
// Swapped-out bitmap, one bit per virtual page, cleared by a sweep after reset.
// ----------------------------------------------------------------------------
module dpt_swap_mem
   import dpt_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     rd_en,
   input  wire logic [PAGE_NUM_BITS-1:0] rd_addr,
   output      logic                     rd_data,
   input  wire logic                     mark_en,
   input  wire logic [PAGE_NUM_BITS-1:0] mark_addr,
   output      logic                     clearing
);

   logic                   mem [PAGE_COUNT];
   logic                   rd_data_ff;
   logic [PAGE_NUM_BITS:0] clr_count_ff;
   logic [PAGE_NUM_BITS:0] clr_count_in;

   assign clearing     = ~clr_count_ff[PAGE_NUM_BITS];
   assign clr_count_in = clr_count_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_count_ff <= '0;
      end else if (clearing) begin
         clr_count_ff <= clr_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clearing) begin
         mem[clr_count_ff[PAGE_NUM_BITS-1:0]] <= 1'b0;
      end else if (mark_en) begin
         mem[mark_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> design/dpt_victim.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dpt_victim
// Victim picker: 16-bit LFSR reduced modulo the frame limit, a byte a cycle.
// ----------------------------------------------------------------------------
module dpt_victim
   import dpt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic [LIMIT_W-1:0]    limit,
   output      logic                  done,
   output      logic [FRAME_BITS-1:0] victim_frame
);

   logic [LFSR_W-1:0]     lfsr_ff;
   logic [LFSR_W-1:0]     lfsr_in;
   logic                  high_ff;
   logic                  low_ff;
   logic                  done_ff;
   logic [FRAME_BITS-1:0] rem_ff;

   // Shifts the remainder left by one bit at a time, with a single
   // compare-and-subtract per bit since the value stays below twice the limit.
   function automatic logic [FRAME_BITS-1:0] reduce_byte(
      input logic [FRAME_BITS-1:0] rem_start,
      input logic [7:0]            bits,
      input logic [LIMIT_W-1:0]    lim
   );
      logic [FRAME_BITS-1:0] r;
      logic [LIMIT_W-1:0]    t;
      r = rem_start;
      for (int i = 7; i >= 0; i--) begin
         t = LIMIT_W'({r, bits[i]});
         if (t >= lim) begin
            t = t - lim;
         end
         r = t[FRAME_BITS-1:0];
      end
      return r;
   endfunction

   assign lfsr_in = {lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5], lfsr_ff[LFSR_W-1:1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         lfsr_ff <= LFSR_SEED;
         high_ff <= 1'b0;
         low_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         if (advance) begin
            lfsr_ff <= lfsr_in;
         end
         high_ff <= advance;
         low_ff  <= high_ff;
         done_ff <= low_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (high_ff) begin
         rem_ff <= reduce_byte('0, lfsr_ff[15:8], limit);
      end else if (low_ff) begin
         rem_ff <= reduce_byte(rem_ff, lfsr_ff[7:0], limit);
      end
   end

   assign done         = done_ff;
   assign victim_frame = rem_ff;

endmodule
`default_nettype wire

>>> design/demand_paging_translator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// demand_paging_translator
// Demand-paged virtual to physical translation with random replacement.
// ----------------------------------------------------------------------------
// A hit or a miss that finds a free frame is resolved in the lookup state and
// its result registered; an evicting miss waits in the victim state while the
// victim picker reduces the high, then the low LFSR byte modulo the limit, and
// then does the eviction write-back. Only one request is in flight at a time.
// Reset: after reset the swapped-out bitmap is cleared one entry a cycle, so
// busy stays high through the whole sweep. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module demand_paging_translator
   import dpt_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // Request channel
   input  wire logic                     start,
   output      logic                     busy,
   input  wire logic [ADDR_W-1:0]        req_virt_addr,
   // Result channel
   output      logic                     rsp_strobe,
   output      logic [PHYS_W-1:0]        rsp_phys_addr,
   output      logic                     rsp_was_hit,
   output      logic                     rsp_evicted,
   output      logic [PAGE_NUM_BITS-1:0] rsp_victim_page,
   output      logic [FRAME_BITS-1:0]    rsp_victim_frame,
   output      logic                     rsp_load_needed,
   // Configuration channel
   input  wire logic                     csr_valid,
   output      logic                     csr_ready,
   input  wire logic [LIMIT_W-1:0]       csr_frame_limit
);

   // The controller walks through a lookup and, when the frame limit is reached,
   // waits for the victim picker before doing the eviction write-back.
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_LOOKUP = 3'b010,
      ST_VICTIM = 3'b100
   } state_type;

   state_type                state_ff, state_in;
   logic [LIMIT_W-1:0]       limit_ff;
   logic [LIMIT_W-1:0]       eff_limit;
   logic [LIMIT_W-1:0]       frames_used_ff, frames_used_in;
   logic [PAGE_NUM_BITS-1:0] page_ff;
   logic [PAGE_BITS-1:0]     offset_ff;

   logic                     rsp_strobe_ff,  rsp_strobe_in;
   logic [FRAME_BITS-1:0]    rsp_frame_ff,   rsp_frame_in;
   logic [PAGE_BITS-1:0]     rsp_offset_ff;
   logic                     rsp_hit_ff,     rsp_hit_in;
   logic                     rsp_evicted_ff, rsp_evicted_in;
   logic [PAGE_NUM_BITS-1:0] rsp_vpage_ff,   rsp_vpage_in;
   logic [FRAME_BITS-1:0]    rsp_vframe_ff,  rsp_vframe_in;
   logic                     rsp_load_ff,    rsp_load_in;

   logic                     accept;
   logic                     clearing;
   logic                     swapped_bit;
   logic                     mark_en;
   logic                     victim_advance;
   logic                     victim_done;
   logic [FRAME_BITS-1:0]    victim_frame;
   logic [PAGE_NUM_BITS-1:0] victim_page;
   slot_hit_type             lookup;
   slot_wr_type              slot_wr;

   // The block is held off while the bitmap sweep runs and while a request
   // is in flight; a shown result never holds off the next request.
   assign busy      = clearing || (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // A limit of zero behaves as one; a limit above the frame count is capped.
   always_comb begin
      if (limit_ff == '0) begin
         eff_limit = LIMIT_W'(1);
      end else if (limit_ff > LIMIT_W'(NUM_FRAMES)) begin
         eff_limit = LIMIT_W'(NUM_FRAMES);
      end else begin
         eff_limit = limit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_frame_limit;
      end
   end

   // Request capture. Bits above the page number are ignored.
   always_ff @(posedge clock) begin
      if (accept) begin
         page_ff   <= req_virt_addr[PAGE_BITS +: PAGE_NUM_BITS];
         offset_ff <= req_virt_addr[PAGE_BITS-1:0];
      end
   end

   // Main control: lookup, free-frame fill, or eviction after the victim
   // picker has reduced the LFSR modulo the limit.
   always_comb begin
      state_in       = state_ff;
      frames_used_in = frames_used_ff;
      victim_advance = 1'b0;
      mark_en        = 1'b0;
      slot_wr.en     = 1'b0;
      slot_wr.index  = lookup.frame;
      slot_wr.page   = page_ff;
      rsp_strobe_in  = 1'b0;
      rsp_frame_in   = lookup.frame;
      rsp_hit_in     = 1'b0;
      rsp_evicted_in = 1'b0;
      rsp_vpage_in   = '0;
      rsp_vframe_in  = '0;
      rsp_load_in    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (lookup.hit) begin
               rsp_strobe_in = 1'b1;
               rsp_hit_in    = 1'b1;
               state_in      = ST_IDLE;
            end else if (frames_used_ff < eff_limit) begin
               slot_wr.en     = 1'b1;
               slot_wr.index  = frames_used_ff[FRAME_BITS-1:0];
               frames_used_in = frames_used_ff + 1'b1;
               rsp_strobe_in  = 1'b1;
               rsp_frame_in   = frames_used_ff[FRAME_BITS-1:0];
               rsp_load_in    = swapped_bit;
               state_in       = ST_IDLE;
            end else begin
               victim_advance = 1'b1;
               state_in       = ST_VICTIM;
            end
         end
         ST_VICTIM: begin
            if (victim_done) begin
               // The victim is always a resident page other than the new one,
               // so marking it cannot change the bit already read for this page.
               mark_en        = 1'b1;
               slot_wr.en     = 1'b1;
               slot_wr.index  = victim_frame;
               rsp_strobe_in  = 1'b1;
               rsp_frame_in   = victim_frame;
               rsp_evicted_in = 1'b1;
               rsp_vpage_in   = victim_page;
               rsp_vframe_in  = victim_frame;
               rsp_load_in    = swapped_bit;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         frames_used_ff <= '0;
         rsp_strobe_ff  <= 1'b0;
      end else begin
         state_ff       <= state_in;
         frames_used_ff <= frames_used_in;
         rsp_strobe_ff  <= rsp_strobe_in;
      end
   end

   // Result payload, loaded together with the strobe.
   always_ff @(posedge clock) begin
      if (rsp_strobe_in) begin
         rsp_frame_ff   <= rsp_frame_in;
         rsp_offset_ff  <= offset_ff;
         rsp_hit_ff     <= rsp_hit_in;
         rsp_evicted_ff <= rsp_evicted_in;
         rsp_vpage_ff   <= rsp_vpage_in;
         rsp_vframe_ff  <= rsp_vframe_in;
         rsp_load_ff    <= rsp_load_in;
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_phys_addr    = PHYS_W'({rsp_frame_ff, rsp_offset_ff});
   assign rsp_was_hit      = rsp_hit_ff;
   assign rsp_evicted      = rsp_evicted_ff;
   assign rsp_victim_page  = rsp_vpage_ff;
   assign rsp_victim_frame = rsp_vframe_ff;
   assign rsp_load_needed  = rsp_load_ff;

   dpt_slots u_slots (
      .clock        (clock),
      .reset        (reset),
      .lookup_page  (page_ff),
      .lookup       (lookup),
      .wr           (slot_wr),
      .victim_index (victim_frame),
      .victim_page  (victim_page)
   );

   // The bitmap is read for the new page as the request is taken; the bit is
   // held until the next request and used at fill or eviction time.
   dpt_swap_mem u_swap_mem (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (accept),
      .rd_addr   (req_virt_addr[PAGE_BITS +: PAGE_NUM_BITS]),
      .rd_data   (swapped_bit),
      .mark_en   (mark_en),
      .mark_addr (victim_page),
      .clearing  (clearing)
   );

   dpt_victim u_victim (
      .clock        (clock),
      .reset        (reset),
      .advance      (victim_advance),
      .limit        (eff_limit),
      .done         (victim_done),
      .victim_frame (victim_frame)
   );

endmodule
`default_nettype wire

>>> test/demand_paging_translator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// demand_paging_translator_tb
// Self-checking bench for the demand paging translator. A behavioural copy of
// the translation table, the victim LFSR and the swapped-out map predicts each
// result. Directed requests cover the frame limit corner cases. Random traffic
// from a small working set then runs under several idling profiles.
// ----------------------------------------------------------------------------
module demand_paging_translator_tb;
   import dpt_pkg::*;

   localparam int CLOCK_PERIOD  = 12;
   localparam int DRAIN_CYCLES  = 8;       // comfortably longer than the eviction path
   localparam int CYCLE_LIMIT   = 400000;  // includes the clearing pass after reset
   localparam int MAX_REPORTS   = 100;
   localparam int SEGMENT_ITEMS = 111;
   localparam int WORKING_SET   = 12;
   localparam int MAX_GAP       = 40;

   // One expected translation, laid out as the result ports.
   typedef struct packed {
      logic [PHYS_W-1:0]        phys_addr;
      logic                     was_hit;
      logic                     evicted;
      logic [PAGE_NUM_BITS-1:0] victim_page;
      logic [FRAME_BITS-1:0]    victim_frame;
      logic                     load_needed;
   } translation_type;

   logic                     clock;
   logic                     reset;
   logic                     start;
   logic                     busy;
   logic [ADDR_W-1:0]        req_virt_addr;
   logic                     rsp_strobe;
   logic [PHYS_W-1:0]        rsp_phys_addr;
   logic                     rsp_was_hit;
   logic                     rsp_evicted;
   logic [PAGE_NUM_BITS-1:0] rsp_victim_page;
   logic [FRAME_BITS-1:0]    rsp_victim_frame;
   logic                     rsp_load_needed;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [LIMIT_W-1:0]       csr_frame_limit;

   // Our own copy of the translator state, advanced once per accepted request.
   logic                     slot_valid_m [NUM_FRAMES];
   logic [PAGE_NUM_BITS-1:0] slot_page_m  [NUM_FRAMES];
   int unsigned              frames_used_m;
   logic [LFSR_W-1:0]        lfsr_m;
   logic                     swapped_m    [PAGE_COUNT];
   logic [LIMIT_W-1:0]       frame_limit_m;
   logic [PAGE_NUM_BITS-1:0] last_victim_page;

   translation_type          pending_translations [$];
   logic [PAGE_NUM_BITS-1:0] working_set [WORKING_SET];

   int idle_percent;
   int fail_count;
   int requests_sent;
   int limit_writes;
   int hit_count;
   int evict_count;
   int load_count;
   int cycle_count;

   demand_paging_translator dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_virt_addr    (req_virt_addr),
      .rsp_strobe       (rsp_strobe),
      .rsp_phys_addr    (rsp_phys_addr),
      .rsp_was_hit      (rsp_was_hit),
      .rsp_evicted      (rsp_evicted),
      .rsp_victim_page  (rsp_victim_page),
      .rsp_victim_frame (rsp_victim_frame),
      .rsp_load_needed  (rsp_load_needed),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_frame_limit  (csr_frame_limit)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Watchdog: a hung handshake or a missing result ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Works out the result of one translation and moves the copied state on.
   // The search takes the lowest matching slot, as the table never holds a
   // page twice. A miss fills the next free frame while the effective limit
   // allows; otherwise the LFSR steps once and picks the victim among the
   // slots below the limit, all of which are valid by then.
   function automatic translation_type translate_address(input logic [ADDR_W-1:0] addr);
      logic [PAGE_NUM_BITS-1:0] page;
      logic [PAGE_BITS-1:0]     offset;
      int unsigned              limit;
      int unsigned              frame;
      int                       i;
      translation_type          t;
      page   = addr[PAGE_BITS +: PAGE_NUM_BITS];
      offset = addr[PAGE_BITS-1:0];
      // A limit of zero behaves as one, anything above the frame count as the count.
      if (frame_limit_m == 0)
         limit = 1;
      else if (frame_limit_m > NUM_FRAMES)
         limit = NUM_FRAMES;
      else
         limit = 32'(frame_limit_m);
      t     = '0;
      frame = 0;
      for (i = 0; i < NUM_FRAMES; i++) begin
         if (!t.was_hit && slot_valid_m[i] && slot_page_m[i] == page) begin
            t.was_hit = 1'b1;
            frame     = i;
         end
      end
      if (t.was_hit) begin
         hit_count++;
      end else begin
         if (frames_used_m < limit) begin
            frame = frames_used_m;
            frames_used_m++;
         end else begin
            // Right-shifting LFSR with taps 16, 14, 13 and 11.
            lfsr_m = {lfsr_m[0] ^ lfsr_m[2] ^ lfsr_m[3] ^ lfsr_m[5], lfsr_m[LFSR_W-1:1]};
            frame          = 32'(lfsr_m) % limit;
            t.evicted      = 1'b1;
            t.victim_frame = FRAME_BITS'(frame);
            t.victim_page  = slot_page_m[frame];
            // The mark is sticky: it survives the page being loaded back.
            swapped_m[slot_page_m[frame]] = 1'b1;
            last_victim_page              = slot_page_m[frame];
            evict_count++;
         end
         slot_valid_m[frame] = 1'b1;
         slot_page_m[frame]  = page;
         t.load_needed       = swapped_m[page];
         if (t.load_needed)
            load_count++;
      end
      t.phys_addr = PHYS_W'((frame << PAGE_BITS) + 32'(offset));
      return t;
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         if (fail_count < MAX_REPORTS)
            $error("%s: expected %0h, got %0h", field, want, got);
         fail_count++;
      end
   endfunction

   // Every strobed result is matched against the oldest outstanding request.
   always @(posedge clock) begin
      translation_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_translations.size() == 0) begin
            if (fail_count < MAX_REPORTS)
               $error("result strobed with no request outstanding");
            fail_count++;
         end else begin
            want = pending_translations.pop_front();
            check_field("phys_addr",    32'(want.phys_addr),    32'(rsp_phys_addr));
            check_field("was_hit",      32'(want.was_hit),      32'(rsp_was_hit));
            check_field("evicted",      32'(want.evicted),      32'(rsp_evicted));
            check_field("victim_page",  32'(want.victim_page),  32'(rsp_victim_page));
            check_field("victim_frame", 32'(want.victim_frame), 32'(rsp_victim_frame));
            check_field("load_needed",  32'(want.load_needed),  32'(rsp_load_needed));
         end
      end
   end

   // Presents one request after an optional random gap and waits until the
   // translator takes it. Start is left high on return so that back-to-back
   // requests need no extra cycle; the next caller lowers it if it idles.
   task automatic send_request(input logic [ADDR_W-1:0] addr);
      int gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < idle_percent)
         gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start         <= 1'b1;
      req_virt_addr <= addr;
      do @(posedge clock); while (busy !== 1'b0);
      pending_translations.push_back(translate_address(addr));
      requests_sent++;
   endtask

   // Stops sending and waits until every outstanding request has its result,
   // then lets the pipeline settle. Always waits for a clock edge, so
   // start is never lowered and raised in the same time step.
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (pending_translations.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // The limit register is only changed with the translator idle.
   task automatic write_frame_limit(input logic [LIMIT_W-1:0] value);
      drain_results();
      csr_valid       <= 1'b1;
      csr_frame_limit <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid     <= 1'b0;
      frame_limit_m  = value;
      limit_writes++;
   endtask

   // With a limit of three the table stops growing at three frames, so the
   // fourth distinct page already evicts; the victim is then requested again
   // and must be loaded back. The address extremes are used as well.
   task automatic test_partial_limit();
      write_frame_limit(4'd3);
      send_request('0);
      send_request('1);
      send_request({10'd0, 12'hFFF});
      send_request({10'd2, 12'h123});
      send_request({10'd3, 12'h456});
      send_request({last_victim_page, 12'h000});
   endtask

   // A limit above the frame count behaves as the full frame count: the
   // remaining free frames fill up before eviction resumes over all eight.
   task automatic test_limit_raised();
      int p;
      write_frame_limit(4'd15);
      for (p = 4; p <= 8; p++)
         send_request({PAGE_NUM_BITS'(p), PAGE_BITS'($urandom())});
      send_request({10'd8, 12'h800});
      send_request({10'd9, 12'h001});
   endtask

   // A limit of zero behaves as one. Slots above the limit keep their pages
   // and still hit, while misses all land in slot zero; pages bounced out of
   // slot zero come back with a load, and keep needing one later on.
   task automatic test_limit_lowered();
      write_frame_limit(4'd0);
      send_request({slot_page_m[NUM_FRAMES-1], 12'hABC});
      send_request({10'd10, 12'h010});
      send_request({10'd11, 12'h011});
      send_request({10'd10, 12'hFFE});
      send_request({10'd11, 12'h000});
   endtask

   // Mostly requests from a small working set so that hits, evictions and
   // reloads are all common, with some whole-range addresses, the address
   // extremes and the most recent victim mixed in.
   function automatic logic [ADDR_W-1:0] pick_address();
      logic [PAGE_NUM_BITS-1:0] page;
      logic [PAGE_BITS-1:0]     offset;
      int unsigned              choice;
      choice = $urandom_range(99);
      if ($urandom_range(3) == 0)
         offset = $urandom_range(1) ? '1 : '0;
      else
         offset = PAGE_BITS'($urandom());
      if (choice < 10)
         return ADDR_W'($urandom());
      else if (choice < 20)
         page = $urandom_range(1) ? '1 : '0;
      else if (choice < 30)
         page = last_victim_page;
      else
         page = working_set[$urandom_range(WORKING_SET - 1)];
      return {page, offset};
   endfunction

   // Three segments, each under its own limit and working set. Now and then
   // the sender holds off until the translator has answered everything.
   task automatic test_random_traffic(input int sender_idle);
      int seg;
      int n;
      int k;
      idle_percent = sender_idle;
      for (seg = 0; seg < 3; seg++) begin
         if (seg == 0)
            write_frame_limit(4'd1);
         else if (seg == 1)
            write_frame_limit(LIMIT_W'(NUM_FRAMES));
         else
            write_frame_limit(LIMIT_W'($urandom_range(15)));
         for (k = 0; k < WORKING_SET; k++)
            working_set[k] = PAGE_NUM_BITS'($urandom());
         for (n = 0; n < SEGMENT_ITEMS; n++) begin
            if ($urandom_range(49) == 0)
               drain_results();
            send_request(pick_address());
         end
      end
   endtask

   initial begin
      int i;
      reset           <= 1'b1;
      start           <= 1'b0;
      req_virt_addr   <= '0;
      csr_valid       <= 1'b0;
      csr_frame_limit <= '0;
      cycle_count     = 0;
      fail_count      = 0;
      requests_sent   = 0;
      limit_writes    = 0;
      hit_count       = 0;
      evict_count     = 0;
      load_count      = 0;
      idle_percent    = 0;
      // The copied state starts as the translator comes out of reset.
      for (i = 0; i < NUM_FRAMES; i++) begin
         slot_valid_m[i] = 1'b0;
         slot_page_m[i]  = '0;
      end
      for (i = 0; i < PAGE_COUNT; i++)
         swapped_m[i] = 1'b0;
      frames_used_m    = 0;
      lfsr_m           = LFSR_SEED;
      frame_limit_m    = LIMIT_RESET;
      last_victim_page = '0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // The translator clears its swapped-out map first; the first request
      // simply waits for that to finish.
      test_partial_limit();
      test_limit_raised();
      test_limit_lowered();
      test_random_traffic(24);
      test_random_traffic(65);
      test_random_traffic(0);
      drain_results();

      $display("Covered %0d requests under %0d frame limit settings.",
               requests_sent, limit_writes);
      $display("Seen %0d hits, %0d evictions and %0d reloads from backing store.",
               hit_count, evict_count, load_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

>>> filelist.f
design/dpt_pkg.sv
design/dpt_slots.sv
design/dpt_swap_mem.sv
design/dpt_victim.sv
design/demand_paging_translator.sv
test/demand_paging_translator_tb.sv
